FILE: rtl/playfair_digraph_cipher_unit_macros.svh
// assertion macros shared by the checker of the playfair digraph cipher unit
// depends on nothing; included by the checker file
`ifndef PLAYFAIR_DIGRAPH_CIPHER_UNIT_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define PFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is held
`define PFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/pfc_pkg.sv
// shared types and constants of the playfair digraph cipher unit
// no dependencies; imported by every module of the block
package pfc_pkg;

  localparam int Side     = 5;
  localparam int Cells    = Side * Side;
  localparam int LetterW  = 5;
  localparam int PosW     = 3;
  localparam int CfgDataW = 50;
  localparam int CfgIdxW  = 2;
  localparam int HighW    = 25;

  localparam logic [LetterW-1:0] FillerCode = 5'd23;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegCellsLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCellsMid  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegCellsHigh = 2'd2;
  localparam logic [CfgIdxW-1:0] RegDecrypt   = 2'd3;

  typedef struct packed {
    logic [LetterW-1:0] letter_code;
    logic               message_end;
  } in_item_t;

  typedef struct packed {
    logic [LetterW-1:0] cipher_letter;
    logic               run_last;
    logic               absent_letter;
  } out_item_t;

  // key square as held in the configuration registers
  typedef struct packed {
    logic                decrypt;
    logic [HighW-1:0]    cells_high;
    logic [CfgDataW-1:0] cells_mid;
    logic [CfgDataW-1:0] cells_low;
  } square_cfg_t;

  typedef struct packed {
    logic [LetterW-1:0] first;
    logic [LetterW-1:0] second;
  } pair_t;

  typedef struct packed {
    logic [LetterW-1:0] first;
    logic [LetterW-1:0] second;
    logic               absent;
  } subst_t;

endpackage

FILE: rtl/pfc_digraph_lookup.sv
// digraph substitution through the 5x5 key square
// depends on pfc_pkg; purely combinational, used by the top level
module pfc_digraph_lookup
  import pfc_pkg::*;
(
  input  square_cfg_t sq_i,
  input  pair_t       pair_i,
  output subst_t      subst_o
);

  logic [Cells*LetterW-1:0] flat;
  logic [LetterW-1:0]       view [Side][Side];
  logic [PosW-1:0]          fr, fc, sr, sc;
  logic                     fa, fb;

  function automatic logic [PosW-1:0] inc5(input logic [PosW-1:0] v);
    inc5 = (v == PosW'(Side - 1)) ? '0 : v + PosW'(1);
  endfunction

  assign flat = {sq_i.cells_high, sq_i.cells_mid, sq_i.cells_low};

  // square as seen in the current mode, rotated half a turn for decryption
  always_comb begin
    for (int r = 0; r < Side; r++) begin
      for (int c = 0; c < Side; c++) begin
        view[r][c] = sq_i.decrypt ? flat[LetterW*(Cells-1-(r*Side+c)) +: LetterW]
                                  : flat[LetterW*(r*Side+c) +: LetterW];
      end
    end
  end

  // locate both letters, last match in reading order wins
  always_comb begin
    fr = '0;
    fc = '0;
    sr = '0;
    sc = '0;
    fa = 1'b0;
    fb = 1'b0;
    for (int r = 0; r < Side; r++) begin
      for (int c = 0; c < Side; c++) begin
        if (view[r][c] == pair_i.first) begin
          fr = PosW'(r);
          fc = PosW'(c);
          fa = 1'b1;
        end
        if (view[r][c] == pair_i.second) begin
          sr = PosW'(r);
          sc = PosW'(c);
          fb = 1'b1;
        end
      end
    end
  end

  // same row, same column or rectangle corners
  always_comb begin
    subst_o.absent = ~(fa & fb);
    if (fr == sr) begin
      subst_o.first  = view[fr][inc5(fc)];
      subst_o.second = view[sr][inc5(sc)];
    end else if (fc == sc) begin
      subst_o.first  = view[inc5(fr)][fc];
      subst_o.second = view[inc5(sr)][sc];
    end else begin
      subst_o.first  = view[fr][sc];
      subst_o.second = view[sr][fc];
    end
  end

endmodule

FILE: rtl/playfair_digraph_cipher_unit.sv
// top level of the playfair digraph cipher unit: pairing, pipeline and output sequencing
// depends on pfc_pkg and pfc_digraph_lookup
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  in_i (in_item_t)
//   out      output     out_valid_o/out_ready_i out_o (out_item_t)
//   cfg      input      cfg_we_i               cfg_index_i, cfg_data_i
//
// an accepted letter is paired with the held one; a pair moves from the pair register
// to the result register and leaves as two letters (four when a doubled letter ends
// the message) on the single output port, one letter per cycle while out_ready_i is
// high; the pair register refills while the result register drains, so new letters are taken during output.
// reset clears the held letter and both stage valids; output stalls back up
// into the pair register and then into in_ready_o.
module playfair_digraph_cipher_unit
  import pfc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  square_cfg_t        sq_q;
  logic               pend_valid_q, pend_valid_d;
  logic [LetterW-1:0] pend_letter_q, pend_letter_d;
  logic               a_valid_q;
  pair_t              a_pair_q, a_pair_d;
  logic               a_quad_q, a_quad_d;
  logic               b_valid_q;
  subst_t             b_res_q;
  logic               b_quad_q;
  logic [1:0]         b_idx_q;
  subst_t             subst;
  logic               in_fire, a_produce, a_move, b_last, b_done;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegCellsLow:  sq_q.cells_low  <= cfg_data_i;
        RegCellsMid:  sq_q.cells_mid  <= cfg_data_i;
        RegCellsHigh: sq_q.cells_high <= cfg_data_i[HighW-1:0];
        RegDecrypt:   sq_q.decrypt    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // handshake control
  assign b_last      = b_quad_q ? (b_idx_q == 2'd3) : (b_idx_q == 2'd1);
  assign b_done      = b_valid_q & out_ready_i & b_last;
  assign a_move      = a_valid_q & (~b_valid_q | b_done);
  assign in_ready_o  = ~a_valid_q | a_move;
  assign in_fire     = in_valid_i & in_ready_o;

  // pairing of the incoming letter with the held one
  always_comb begin
    pend_valid_d  = pend_valid_q;
    pend_letter_d = pend_letter_q;
    a_pair_d      = '{first: in_i.letter_code, second: FillerCode};
    a_quad_d      = 1'b0;
    a_produce     = pend_valid_q | in_i.message_end;
    if (!pend_valid_q) begin
      if (!in_i.message_end) begin
        pend_valid_d  = 1'b1;
        pend_letter_d = in_i.letter_code;
      end
    end else if (pend_letter_q != in_i.letter_code) begin
      a_pair_d      = '{first: pend_letter_q, second: in_i.letter_code};
      pend_valid_d  = 1'b0;
      pend_letter_d = '0;
    end else begin
      // doubled letter: filler pair, repeated when it also ends the message
      a_quad_d      = in_i.message_end;
      pend_valid_d  = ~in_i.message_end;
      pend_letter_d = in_i.message_end ? '0 : in_i.letter_code;
    end
  end

  // held letter and pair register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q  <= 1'b0;
      pend_letter_q <= '0;
      a_valid_q     <= 1'b0;
    end else begin
      if (in_fire) begin
        pend_valid_q  <= pend_valid_d;
        pend_letter_q <= pend_letter_d;
      end
      if (in_fire) begin
        a_valid_q <= a_produce;
      end else if (a_move) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_pair_q <= a_pair_d;
      a_quad_q <= a_quad_d;
    end
  end

  pfc_digraph_lookup u_lookup (
    .sq_i    (sq_q),
    .pair_i  (a_pair_q),
    .subst_o (subst)
  );

  // result register and output letter counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_idx_q   <= '0;
    end else begin
      if (a_move) begin
        b_valid_q <= 1'b1;
        b_idx_q   <= '0;
      end else if (b_done) begin
        b_valid_q <= 1'b0;
      end else if (b_valid_q && out_ready_i) begin
        b_idx_q <= b_idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      b_res_q  <= subst;
      b_quad_q <= a_quad_q;
    end
  end

  // output transaction
  assign out_valid_o         = b_valid_q;
  assign out_o.cipher_letter = b_idx_q[0] ? b_res_q.second : b_res_q.first;
  assign out_o.run_last      = b_last;
  assign out_o.absent_letter = b_res_q.absent;

endmodule

FILE: rtl/pfc_checker.sv
// port-level checks of the playfair digraph cipher unit, bound to the top level
// depends on pfc_pkg and the assertion macro header
`include "playfair_digraph_cipher_unit_macros.svh"

module pfc_checker
  import pfc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_o
);

  // a stalled output transaction holds its payload
  `PFC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_o))

  // a letter that is not the last of its run is followed at once by the next one
  `PFC_ASSERT_NEXT(a_pair_follow, clk_i, rst_ni, out_valid_o && out_ready_i && !out_o.run_last, out_valid_o)

  // both letters of a pair carry the same absent flag
  `PFC_ASSERT_NEXT(a_absent_pair, clk_i, rst_ni, out_valid_o && out_ready_i && !out_o.run_last, out_o.absent_letter == $past(out_o.absent_letter))

  // an empty output side never blocks the input
  `PFC_ASSERT_NOW(a_ready_idle, clk_i, rst_ni, !out_valid_o, in_ready_o)

endmodule

bind playfair_digraph_cipher_unit pfc_checker u_pfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);
